[hw/rtl/hdu_pkg.sv]
package hdu_pkg;

   // Field widths of the packet word and of the decoded hit.
   localparam int WORD_WIDTH   = 64;
   localparam int TIME_WIDTH   = 48;
   localparam int PIXEL_WIDTH  = 10;
   localparam int TOT_WIDTH    = 10;
   localparam int TOA_WIDTH    = 14;
   localparam int FINE_WIDTH   = 4;
   localparam int LAYOUT_WIDTH = 8;
   localparam int COUNT_WIDTH  = 13;
   localparam int PERIOD_WIDTH = 28;
   localparam int CSR_DATA_WIDTH  = 28;
   localparam int CSR_INDEX_WIDTH = 1;

   // Word classification codes.
   localparam logic [23:0] HEADER_SIGNATURE = 24'h585054;
   localparam logic [7:0]  TOP_TRIGGER      = 8'h6F;
   localparam logic [3:0]  NIBBLE_TIMER     = 4'h4;
   localparam logic [3:0]  NIBBLE_HIT       = 4'hB;
   localparam logic [3:0]  TIMER_SEL_LOW    = 4'h4;
   localparam logic [3:0]  TIMER_SEL_HIGH   = 4'h5;

   // Chip layout modes.
   localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_PLAIN  = 8'd0;
   localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_FLIP_XY = 8'd1;
   localparam logic [LAYOUT_WIDTH-1:0] LAYOUT_FLIP_X  = 8'd2;
   localparam logic [PIXEL_WIDTH-1:0]  PIXEL_SPAN     = 10'd255;

   // Register reset values.
   localparam logic [PERIOD_WIDTH-1:0] FRAME_PERIOD_RESET = 28'd16666667;
   localparam logic [PIXEL_WIDTH-1:0]  CHIP_GAP_RESET     = 10'd260;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_PERIOD    = 1'b0,
      CSR_CHIP_GAP_OFFSET = 1'b1
   } csr_index_type;

   // Time context handed from the time tracker to the hit formatter.
   typedef struct packed {
      logic                    hit_en;
      logic [TIME_WIDTH-1:0]   hit_time;
      logic [TIME_WIDTH-1:0]   trigger_time;
      logic [LAYOUT_WIDTH-1:0] layout_mode;
   } hdu_ctx_type;

   // One decoded hit.
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_x;
      logic [PIXEL_WIDTH-1:0] pixel_y;
      logic [TOT_WIDTH-1:0]   over_threshold;
      logic [TOA_WIDTH-1:0]   arrival_coarse;
      logic [FINE_WIDTH-1:0]  arrival_fine;
      logic [TIME_WIDTH-1:0]  hit_time;
      logic [TIME_WIDTH-1:0]  flight_time;
   } hdu_result_type;

endpackage

[hw/rtl/hdu_channels.sv]
// Packet word input channel.
interface hdu_req_if;
   import hdu_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// Decoded hit output channel.
interface hdu_rsp_if;
   import hdu_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] pixel_x;
   logic [PIXEL_WIDTH-1:0] pixel_y;
   logic [TOT_WIDTH-1:0]   over_threshold;
   logic [TOA_WIDTH-1:0]   arrival_coarse;
   logic [FINE_WIDTH-1:0]  arrival_fine;
   logic [TIME_WIDTH-1:0]  hit_time;
   logic [TIME_WIDTH-1:0]  flight_time;
   modport source (output valid, output pixel_x, output pixel_y, output over_threshold,
                   output arrival_coarse, output arrival_fine, output hit_time,
                   output flight_time, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input over_threshold,
                 input arrival_coarse, input arrival_fine, input hit_time,
                 input flight_time, output ready);
endinterface

// Register write channel.
interface hdu_csr_if;
   import hdu_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/pixel_detector_hit_decoder_unit.sv]
// Pixel detector hit decoder. Takes one 64-bit packet word per cycle on req_ch and
// gives one decoded hit on rsp_ch for each hit word inside a chunk; headers, trigger
// and timer words give no result but update the time state, and unknown words give
// no result. A word passes an input register and then the result register, and a new
// word is taken every cycle unless the input is stalled. The rate is set by the
// single decode pass between those registers; back pressure on rsp_ch stalls the
// input only once both registers hold a word. Register writes on csr_ch are always
// taken: index 0 is the frame period, index 1 the chip gap offset, and they should
// only be written while no word is in flight.
module pixel_detector_hit_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   hdu_req_if.sink     req_ch,
   hdu_rsp_if.source   rsp_ch,
   hdu_csr_if.sink     csr_ch
);
   import hdu_pkg::*;

   logic                    s1_valid_ff, s1_valid_in;
   logic [WORD_WIDTH-1:0]   s1_word_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   hdu_result_type          rsp_ff;
   logic [PERIOD_WIDTH-1:0] frame_period_ff, frame_period_in;
   logic [PIXEL_WIDTH-1:0]  chip_gap_ff, chip_gap_in;

   logic           out_free;
   logic           advance;
   hdu_ctx_type    ctx;
   hdu_result_type result;

   // Pipeline control: the output register frees when empty or taken.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || out_free;
   assign advance      = s1_valid_ff && out_free;
   assign s1_valid_in  = req_ch.ready ? req_ch.valid : s1_valid_ff;
   assign rsp_valid_in = out_free ? (advance && ctx.hit_en) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input word register.
   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         s1_word_ff <= req_ch.word;
      end
   end

   hdu_time_tracker u_time_tracker (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .word   (s1_word_ff),
      .ctx    (ctx)
   );

   hdu_hit_formatter u_hit_formatter (
      .word            (s1_word_ff),
      .ctx             (ctx),
      .frame_period    (frame_period_ff),
      .chip_gap_offset (chip_gap_ff),
      .result          (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (out_free && advance && ctx.hit_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.pixel_x        = rsp_ff.pixel_x;
   assign rsp_ch.pixel_y        = rsp_ff.pixel_y;
   assign rsp_ch.over_threshold = rsp_ff.over_threshold;
   assign rsp_ch.arrival_coarse = rsp_ff.arrival_coarse;
   assign rsp_ch.arrival_fine   = rsp_ff.arrival_fine;
   assign rsp_ch.hit_time       = rsp_ff.hit_time;
   assign rsp_ch.flight_time    = rsp_ff.flight_time;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      frame_period_in = frame_period_ff;
      chip_gap_in     = chip_gap_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_FRAME_PERIOD:    frame_period_in = csr_ch.data[PERIOD_WIDTH-1:0];
            CSR_CHIP_GAP_OFFSET: chip_gap_in     = csr_ch.data[PIXEL_WIDTH-1:0];
            default:             frame_period_in = frame_period_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_period_ff <= FRAME_PERIOD_RESET;
         chip_gap_ff     <= CHIP_GAP_RESET;
      end else begin
         frame_period_ff <= frame_period_in;
         chip_gap_ff     <= chip_gap_in;
      end
   end

endmodule

[hw/rtl/hdu_time_tracker.sv]
module hdu_time_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic [hdu_pkg::WORD_WIDTH-1:0]    word,
   output hdu_pkg::hdu_ctx_type              ctx
);
   import hdu_pkg::*;

   logic [TIME_WIDTH-1:0]   global_time_ff, global_time_in;
   logic [31:0]             timer_low_ff, timer_low_in;
   logic [TIME_WIDTH-1:0]   trigger_time_ff, trigger_time_in;
   logic [LAYOUT_WIDTH-1:0] layout_ff, layout_in;
   logic [COUNT_WIDTH-1:0]  words_left_ff, words_left_in;

   logic [7:0]  top;
   logic        is_header;
   logic        in_chunk;
   logic [31:0] trig_low;
   logic [15:0] trig_upper;
   logic [29:0] local_time;
   logic [17:0] hit_upper;

   assign top       = word[63:56];
   assign is_header = (word[23:0] == HEADER_SIGNATURE);
   assign in_chunk  = (words_left_ff != '0);

   // Trigger time extension against the global time, with wrap carry.
   assign trig_low   = word[43:12];
   assign trig_upper = global_time_ff[47:32] + 16'(trig_low < global_time_ff[31:0]);

   // Hit time extension: coarse and arrival time form the low 30 bits.
   assign local_time = {word[15:0], word[43:30]};
   assign hit_upper  = global_time_ff[47:30] + 18'(local_time < global_time_ff[29:0]);

   // Next state of the chunk and timer bookkeeping.
   always_comb begin
      global_time_in  = global_time_ff;
      timer_low_in    = timer_low_ff;
      trigger_time_in = trigger_time_ff;
      layout_in       = layout_ff;
      words_left_in   = words_left_ff;
      if (enable) begin
         priority if (is_header) begin
            global_time_in  = '0;
            timer_low_in    = '0;
            trigger_time_in = '0;
            layout_in       = word[39:32];
            words_left_in   = word[63:51];
         end else if (in_chunk) begin
            words_left_in = words_left_ff - COUNT_WIDTH'(1);
            priority if (top == TOP_TRIGGER) begin
               trigger_time_in = {trig_upper, trig_low};
            end else if (top[7:4] == NIBBLE_TIMER) begin
               if (top[3:0] == TIMER_SEL_LOW) begin
                  timer_low_in = word[47:16];
               end else if (top[3:0] == TIMER_SEL_HIGH) begin
                  global_time_in = {word[31:16], timer_low_ff};
               end
            end else begin
               // Hit and unknown payload words leave the time state alone.
            end
         end else begin
            // Words outside a chunk are dropped.
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_time_ff  <= '0;
         timer_low_ff    <= '0;
         trigger_time_ff <= '0;
         layout_ff       <= '0;
         words_left_ff   <= '0;
      end else begin
         global_time_ff  <= global_time_in;
         timer_low_ff    <= timer_low_in;
         trigger_time_ff <= trigger_time_in;
         layout_ff       <= layout_in;
         words_left_ff   <= words_left_in;
      end
   end

   // Context for the hit word, taken from the state before this word.
   assign ctx.hit_en       = enable && !is_header && in_chunk && (top[7:4] == NIBBLE_HIT);
   assign ctx.hit_time     = {hit_upper, local_time};
   assign ctx.trigger_time = trigger_time_ff;
   assign ctx.layout_mode  = layout_ff;

endmodule

[hw/rtl/hdu_hit_formatter.sv]
module hdu_hit_formatter (
   input  logic [hdu_pkg::WORD_WIDTH-1:0]   word,
   input  hdu_pkg::hdu_ctx_type             ctx,
   input  logic [hdu_pkg::PERIOD_WIDTH-1:0] frame_period,
   input  logic [hdu_pkg::PIXEL_WIDTH-1:0]  chip_gap_offset,
   output hdu_pkg::hdu_result_type          result
);
   import hdu_pkg::*;

   logic [TIME_WIDTH:0]    diff;
   logic [TIME_WIDTH-1:0]  flight;
   logic [15:0]            addr;
   logic [PIXEL_WIDTH-1:0] raw_x;
   logic [PIXEL_WIDTH-1:0] raw_y;
   logic [PIXEL_WIDTH-1:0] pix_x;
   logic [PIXEL_WIDTH-1:0] pix_y;

   // Time of flight; the borrow tells that the hit precedes the trigger.
   assign diff = {1'b0, ctx.hit_time} - {1'b0, ctx.trigger_time};

   always_comb begin
      flight = diff[TIME_WIDTH-1:0];
      if (diff[TIME_WIDTH]) begin
         flight = diff[TIME_WIDTH-1:0] + TIME_WIDTH'(frame_period);
      end
   end

   // Pixel address split into double column, super pixel and pixel.
   assign addr  = word[59:44];
   assign raw_x = PIXEL_WIDTH'({addr[15:9], 1'b0}) + PIXEL_WIDTH'(addr[2]);
   assign raw_y = PIXEL_WIDTH'({addr[8:3], 2'b00}) + PIXEL_WIDTH'(addr[1:0]);

   // Chip placement; unknown layouts leave the coordinates as they are.
   always_comb begin
      priority if (ctx.layout_mode == LAYOUT_PLAIN) begin
         pix_x = raw_x + chip_gap_offset;
         pix_y = raw_y;
      end else if (ctx.layout_mode == LAYOUT_FLIP_XY) begin
         pix_x = PIXEL_SPAN - raw_x + chip_gap_offset;
         pix_y = PIXEL_SPAN - raw_y + chip_gap_offset;
      end else if (ctx.layout_mode == LAYOUT_FLIP_X) begin
         pix_x = PIXEL_SPAN - raw_x;
         pix_y = PIXEL_SPAN - raw_y + chip_gap_offset;
      end else begin
         pix_x = raw_x;
         pix_y = raw_y;
      end
   end

   assign result.pixel_x        = pix_x;
   assign result.pixel_y        = pix_y;
   assign result.flight_time    = flight;
   assign result.over_threshold = word[29:20];
   assign result.arrival_coarse = word[43:30];
   assign result.arrival_fine   = word[19:16];
   assign result.hit_time       = ctx.hit_time;

endmodule

[hw/rtl/hdu_checker.sv]
module hdu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [63:0] req_word,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_hit_time,
   input logic [47:0] rsp_flight_time
);

   logic req_taken;
   assign req_taken = req_valid && req_ready;

   // A stalled result word keeps its timestamps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_time)
         && $stable(rsp_flight_time))
      else $error("stalled result word changed");

   // A new result follows an accepted word that passed the input and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_taken, 2))
      else $error("result word without an accepted input word");

   // That word must have been a hit word.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_word[63:60] == 4'hB, 2))
      else $error("result word caused by a non-hit word");

   // The input side is never blocked while both registers are empty.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_taken) |-> req_ready)
      else $error("input stalled with an empty pipeline");

endmodule

bind pixel_detector_hit_decoder_unit hdu_checker u_hdu_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_word        (req_ch.word),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_hit_time    (rsp_ch.hit_time),
   .rsp_flight_time (rsp_ch.flight_time)
);
